// ----- sv/atr_pkg.sv -----
// Shared constants and controller/datapath interface types for the
// average true range filter. No dependencies.
`default_nettype none
package atr_pkg;

	localparam int PRICE_W    = 32;
	localparam int FRAC_W     = 16;
	localparam int ATR_W      = 48;
	localparam int SUM_W      = 40;
	localparam int PER_W      = 9;
	localparam int MAX_PERIOD = 256;
	localparam int PROD_W     = ATR_W + PER_W - 1;
	localparam int DIV_W      = ATR_W + PER_W;
	localparam int DIV_CNT_W  = $clog2(DIV_W);

	localparam logic [PER_W-1:0]     RESET_PERIOD = PER_W'(14);
	localparam logic [DIV_CNT_W-1:0] DIV_LAST     = DIV_CNT_W'(DIV_W - 1);

	typedef struct packed {
		logic capture;
		logic calc_tr;
		logic update;
		logic mul;
		logic load_div;
		logic div_step;
		logic finish;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic smooth;
		logic seed_div;
		logic div_last;
	} sts_t;

endpackage
`default_nettype wire

// ----- sv/atr_ctrl.sv -----
// Sequencing controller for the average true range filter.
// Depends on atr_pkg; drives atr_dpath through cmd_t and reads sts_t.
`default_nettype none
module atr_ctrl (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  wire logic         out_stall,
	input  wire atr_pkg::sts_t sts,
	output atr_pkg::cmd_t     cmd
);
	import atr_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_TR   = 3'd1;
	localparam logic [2:0] S_UPD  = 3'd2;
	localparam logic [2:0] S_MUL  = 3'd3;
	localparam logic [2:0] S_LOAD = 3'd4;
	localparam logic [2:0] S_DIV  = 3'd5;
	localparam logic [2:0] S_FIN  = 3'd6;
	localparam logic [2:0] S_OUT  = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.capture = in_valid;
				if (in_valid) state_d = S_TR;
			end
			S_TR: begin
				cmd.calc_tr = 1'b1;
				state_d     = S_UPD;
			end
			S_UPD: begin
				cmd.update = 1'b1;
				if (sts.smooth) state_d = S_MUL;
				else if (sts.seed_div) state_d = S_LOAD;
				else state_d = S_OUT;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_LOAD;
			end
			S_LOAD: begin
				cmd.load_div = 1'b1;
				state_d      = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) state_d = S_FIN;
			end
			S_FIN: begin
				cmd.finish = 1'b1;
				state_d    = S_OUT;
			end
			S_OUT: begin
				cmd.load_out = out_free;
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	a_div_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && sts.div_last) |=> (state_q == S_FIN))
		else $error("division did not finish after its last step");

	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_OUT))
		else $error("result raised outside output state");

	a_out_no_clobber: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_out && out_valid_q) |-> !out_stall)
		else $error("pending result overwritten");

endmodule
`default_nettype wire

// ----- sv/atr_dpath.sv -----
// Datapath for the average true range filter: period register, history,
// true range, seed sum, 48x8 multiplier and bit-serial restoring divider.
// Depends on atr_pkg; controlled by atr_ctrl.
`default_nettype none
module atr_dpath (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_wr_en,
	input  wire logic [atr_pkg::PER_W-1:0]    cfg_wr_data,
	input  wire logic [atr_pkg::PRICE_W-1:0]  bar_high,
	input  wire logic [atr_pkg::PRICE_W-1:0]  bar_low,
	input  wire logic [atr_pkg::PRICE_W-1:0]  bar_close,
	input  wire logic                         restart,
	input  wire atr_pkg::cmd_t                cmd,
	output atr_pkg::sts_t                     sts,
	output logic [atr_pkg::PRICE_W-1:0]       true_range,
	output logic                              tr_valid,
	output logic [atr_pkg::ATR_W-1:0]         atr,
	output logic                              atr_valid
);
	import atr_pkg::*;

	logic [PER_W-1:0]     period_q;
	logic [PER_W-1:0]     n_eff;
	logic [PER_W-1:0]     n_q;
	logic [PRICE_W-1:0]   hi_q;
	logic [PRICE_W-1:0]   lo_q;
	logic [PRICE_W-1:0]   cl_q;
	logic                 restart_q;

	logic [PRICE_W-1:0]   last_close_q;
	logic                 have_last_q;
	logic [PER_W-1:0]     seed_count_q;
	logic [SUM_W-1:0]     seed_sum_q;
	logic [ATR_W-1:0]     atr_q;
	logic                 seeded_q;

	logic [PRICE_W-1:0]   tr_q;
	logic                 tr_ok_q;
	logic [PROD_W-1:0]    prod_q;
	logic [DIV_W-1:0]     dq_q;
	logic [PER_W-1:0]     rem_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;

	logic [PRICE_W-1:0]   tr_top;
	logic [PRICE_W-1:0]   tr_bot;
	logic [PER_W-1:0]     count_inc;
	logic [PER_W-1:0]     n_less1;
	logic [PER_W:0]       trial;
	logic [PER_W:0]       trial_diff;
	logic                 trial_ge;
	logic [DIV_W-1:0]     smooth_dividend;
	logic [DIV_W-1:0]     seed_dividend;

	always_comb begin
		if (period_q == '0) n_eff = PER_W'(1);
		else if (period_q > PER_W'(MAX_PERIOD)) n_eff = PER_W'(MAX_PERIOD);
		else n_eff = period_q;
	end

	assign tr_top     = (hi_q > last_close_q) ? hi_q : last_close_q;
	assign tr_bot     = (lo_q < last_close_q) ? lo_q : last_close_q;
	assign count_inc  = seed_count_q + PER_W'(1);
	assign n_less1    = n_q - PER_W'(1);
	assign trial      = {rem_q, dq_q[DIV_W-1]};
	assign trial_diff = trial - {1'b0, n_q};
	assign trial_ge   = (trial >= {1'b0, n_q});

	assign smooth_dividend = {{(DIV_W-PROD_W){1'b0}}, prod_q}
		+ {{(DIV_W-PRICE_W-FRAC_W){1'b0}}, tr_q, {FRAC_W{1'b0}}};
	assign seed_dividend = {{(DIV_W-SUM_W-FRAC_W){1'b0}}, seed_sum_q, {FRAC_W{1'b0}}};

	assign sts.smooth   = tr_ok_q && seeded_q;
	assign sts.seed_div = tr_ok_q && !seeded_q && (count_inc >= n_q);
	assign sts.div_last = (div_cnt_q == DIV_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q     <= RESET_PERIOD;
			last_close_q <= '0;
			have_last_q  <= 1'b0;
			seed_count_q <= '0;
			seed_sum_q   <= '0;
			atr_q        <= '0;
			seeded_q     <= 1'b0;
		end else begin
			if (cfg_wr_en) period_q <= cfg_wr_data;
			if (cmd.calc_tr) begin
				if (restart_q) begin
					seed_count_q <= '0;
					seed_sum_q   <= '0;
					atr_q        <= '0;
					seeded_q     <= 1'b0;
				end
				last_close_q <= cl_q;
				have_last_q  <= 1'b1;
			end
			if (cmd.update && tr_ok_q && !seeded_q) begin
				seed_sum_q   <= seed_sum_q + {{(SUM_W-PRICE_W){1'b0}}, tr_q};
				seed_count_q <= count_inc;
			end
			if (cmd.finish) begin
				atr_q    <= dq_q[ATR_W-1:0];
				seeded_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			hi_q      <= bar_high;
			lo_q      <= bar_low;
			cl_q      <= bar_close;
			restart_q <= restart;
			n_q       <= n_eff;
		end
		if (cmd.calc_tr) begin
			tr_q    <= tr_top - tr_bot;
			tr_ok_q <= have_last_q && !restart_q;
		end
		if (cmd.mul) prod_q <= atr_q * n_less1[PER_W-2:0];
		if (cmd.load_div) begin
			dq_q      <= seeded_q ? smooth_dividend : seed_dividend;
			rem_q     <= '0;
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			dq_q      <= {dq_q[DIV_W-2:0], trial_ge};
			rem_q     <= trial_ge ? trial_diff[PER_W-1:0] : trial[PER_W-1:0];
			div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
		end
		if (cmd.load_out) begin
			true_range <= tr_ok_q ? tr_q : '0;
			tr_valid   <= tr_ok_q;
			atr        <= seeded_q ? atr_q : '0;
			atr_valid  <= seeded_q;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		seed_count_q <= PER_W'(MAX_PERIOD))
		else $error("seed count beyond maximum period");

	a_seeded_count: assert property (@(posedge clk) disable iff (!arst_n)
		seeded_q |-> (seed_count_q != '0))
		else $error("average seeded without any true range");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.div_step) |-> (rem_q < n_q))
		else $error("division remainder not below divisor");

endmodule
`default_nettype wire

// ----- sv/average_true_range_filter.sv -----
// Wilder average true range filter, top level. One result per bar.
// A bar that needs no division skips the 57-step bit-serial divider, which seeds and
// smooths the average. One bar in flight; the next is taken the cycle after its result
// is loaded into the output register, and output stalls hold that load back.
// Reset clears history and sets period to 14.
`default_nettype none
module average_true_range_filter (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_wr_en,
	input  wire logic [atr_pkg::PER_W-1:0]   cfg_wr_data,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [atr_pkg::PRICE_W-1:0] bar_high,
	input  wire logic [atr_pkg::PRICE_W-1:0] bar_low,
	input  wire logic [atr_pkg::PRICE_W-1:0] bar_close,
	input  wire logic                        restart,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [atr_pkg::PRICE_W-1:0]      true_range,
	output logic                             tr_valid,
	output logic [atr_pkg::ATR_W-1:0]        atr,
	output logic                             atr_valid
);
	import atr_pkg::*;

	cmd_t cmd;
	sts_t sts;

	atr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	atr_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.bar_high    (bar_high),
		.bar_low     (bar_low),
		.bar_close   (bar_close),
		.restart     (restart),
		.cmd         (cmd),
		.sts         (sts),
		.true_range  (true_range),
		.tr_valid    (tr_valid),
		.atr         (atr),
		.atr_valid   (atr_valid)
	);

endmodule
`default_nettype wire

// ----- verif/average_true_range_filter_tb.sv -----
// Self-checking testbench for average_true_range_filter: directed and random bars under a
// range of periods, with a bar-by-bar predictor of the Wilder average true range.
// Depends on atr_pkg and the average_true_range_filter RTL.
`default_nettype none
module average_true_range_filter_tb;
	import atr_pkg::*;

	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int BAR_TARGET  = 1650;

	typedef struct packed {
		logic [PRICE_W-1:0] hi;
		logic [PRICE_W-1:0] lo;
		logic [PRICE_W-1:0] cl;
		logic               rst;
	} bar_t;

	typedef struct packed {
		logic [PRICE_W-1:0] tr;
		logic               tr_ok;
		logic [ATR_W-1:0]   avg;
		logic               avg_ok;
	} atr_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_wr_en = 1'b0;
	logic [PER_W-1:0]   cfg_wr_data = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [PRICE_W-1:0] bar_high = '0;
	logic [PRICE_W-1:0] bar_low = '0;
	logic [PRICE_W-1:0] bar_close = '0;
	logic               restart = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [PRICE_W-1:0] true_range;
	logic               tr_valid;
	logic [ATR_W-1:0]   atr;
	logic               atr_valid;

	average_true_range_filter uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.bar_high   (bar_high),
		.bar_low    (bar_low),
		.bar_close  (bar_close),
		.restart    (restart),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.true_range (true_range),
		.tr_valid   (tr_valid),
		.atr        (atr),
		.atr_valid  (atr_valid)
	);

	always #2 clk = ~clk;

	// predictor state
	logic [PER_W-1:0]   per_reg;
	logic [PRICE_W-1:0] prev_close;
	logic               have_prev;
	logic [PER_W-1:0]   seed_cnt;
	logic [SUM_W-1:0]   seed_acc;
	logic [ATR_W-1:0]   atr_acc;
	logic               is_seeded;

	bar_t               pending_bars[$];
	atr_result_t        expected_atr[$];
	bar_t               cur_bar = '0;
	bit                 bar_loaded = 1'b0;
	int                 burst_left = 1;
	int                 gap_left = 0;
	int                 stall_mode = 0;
	int                 stall_left = 0;
	int                 fail_count = 0;
	int                 cycle_count = 0;
	int                 bars_sent = 0;
	int                 phase_no = 0;
	int                 kind;
	int                 bar_count;
	int                 k;
	bit                 start_fresh;
	logic [PER_W-1:0]   new_period;
	logic [PRICE_W-1:0] walk_price = 32'h4000_0000;
	atr_result_t        want_res;
	bar_t               next_bar;

	function automatic atr_result_t predict_atr(bar_t b);
		atr_result_t        r;
		logic [PRICE_W-1:0] top;
		logic [PRICE_W-1:0] bot;
		logic [63:0]        n;
		logic [63:0]        acc;
		r = '0;
		if (per_reg == 0)
			n = 64'd1;
		else if (per_reg > MAX_PERIOD)
			n = 64'(MAX_PERIOD);
		else
			n = 64'(per_reg);
		if (b.rst) begin
			prev_close = '0;
			have_prev = 1'b0;
			seed_cnt = '0;
			seed_acc = '0;
			atr_acc = '0;
			is_seeded = 1'b0;
		end
		if (have_prev) begin
			top = (b.hi > prev_close) ? b.hi : prev_close;
			bot = (b.lo < prev_close) ? b.lo : prev_close;
			r.tr = top - bot;
			r.tr_ok = 1'b1;
			if (!is_seeded) begin
				seed_acc = seed_acc + SUM_W'(r.tr);
				seed_cnt = seed_cnt + 1'b1;
				if (64'(seed_cnt) >= n) begin
					acc = 64'(seed_acc) << FRAC_W;
					atr_acc = ATR_W'(acc / n);
					is_seeded = 1'b1;
				end
			end else begin
				acc = 64'(atr_acc) * (n - 64'd1) + (64'(r.tr) << FRAC_W);
				atr_acc = ATR_W'(acc / n);
			end
		end
		prev_close = b.cl;
		have_prev = 1'b1;
		if (is_seeded) begin
			r.avg = atr_acc;
			r.avg_ok = 1'b1;
		end
		return r;
	endfunction

	function automatic bar_t gen_bar();
		bar_t b;
		int   mode;
		int   spread;
		mode = $urandom_range(0, 99);
		spread = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1 << 20) : $urandom_range(0, 500);
		walk_price = walk_price + $urandom_range(0, 2 * spread) - spread;
		if (mode < 80) begin
			b.hi = walk_price + $urandom_range(0, spread);
			b.lo = walk_price - $urandom_range(0, spread);
			b.cl = walk_price + $urandom_range(0, spread) - spread / 2;
		end else if (mode < 90) begin
			b.hi = $urandom;
			b.lo = $urandom;
			b.cl = $urandom;
		end else if (mode < 95) begin
			b.hi = walk_price;
			b.lo = walk_price + spread + 1;
			b.cl = walk_price + $urandom_range(0, spread);
		end else begin
			b.hi = $urandom_range(0, 1) ? '1 : '0;
			b.lo = $urandom_range(0, 1) ? '1 : '0;
			b.cl = $urandom_range(0, 1) ? '1 : '0;
			walk_price = $urandom;
		end
		b.rst = ($urandom_range(0, 99) < 3);
		return b;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		fail_count++;
		if (fail_count <= 40)
			$display("mismatch %s: got %0h expected %0h (cycle %0d)", what, got, want,
				cycle_count);
	endtask

	task automatic push_bar(input logic [PRICE_W-1:0] hi, input logic [PRICE_W-1:0] lo,
		input logic [PRICE_W-1:0] cl, input logic rst);
		bar_t b;
		b.hi = hi;
		b.lo = lo;
		b.cl = cl;
		b.rst = rst;
		pending_bars.push_back(b);
		bars_sent++;
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_bars.size() != 0 || bar_loaded || expected_atr.size() != 0);
	endtask

	task automatic set_period(input logic [PER_W-1:0] value);
		wait_drained();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		per_reg = value;
	endtask

	// sender: bursts of transactions separated by random gaps
	always @(negedge clk) begin
		if (!bar_loaded) begin
			if (gap_left != 0)
				gap_left--;
			else if (pending_bars.size() != 0) begin
				cur_bar = pending_bars.pop_front();
				bar_loaded = 1'b1;
				if (burst_left > 1)
					burst_left--;
				else begin
					burst_left = $urandom_range(1, 8);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 90);
				end
			end
		end
		in_valid <= bar_loaded;
		bar_high <= cur_bar.hi;
		bar_low <= cur_bar.lo;
		bar_close <= cur_bar.cl;
		restart <= cur_bar.rst;
	end

	// receiver: stall pattern of its own
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 2);
			stall_left = (stall_mode == 1) ? $urandom_range(1, 30) : $urandom_range(1, 60);
		end
		stall_left--;
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= 1'b1;
			default: out_stall <= ($urandom_range(0, 1) == 1);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			expected_atr.push_back(predict_atr({bar_high, bar_low, bar_close, restart}));
			bar_loaded = 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_atr.size() == 0)
				report_mismatch("unexpected result, true_range", 64'(true_range), 64'd0);
			else begin
				want_res = expected_atr.pop_front();
				if (true_range !== want_res.tr)
					report_mismatch("true_range", 64'(true_range), 64'(want_res.tr));
				if (tr_valid !== want_res.tr_ok)
					report_mismatch("tr_valid", 64'(tr_valid), 64'(want_res.tr_ok));
				if (atr !== want_res.avg)
					report_mismatch("atr", 64'(atr), 64'(want_res.avg));
				if (atr_valid !== want_res.avg_ok)
					report_mismatch("atr_valid", 64'(atr_valid), 64'(want_res.avg_ok));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		per_reg = RESET_PERIOD;
		prev_close = '0;
		have_prev = 1'b0;
		seed_cnt = '0;
		seed_acc = '0;
		atr_acc = '0;
		is_seeded = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		push_bar(32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 1'b0);
		push_bar(32'h0, 32'h0, 32'h0, 1'b0);
		push_bar(32'h0, 32'hFFFF_FFFF, 32'h0, 1'b0);
		push_bar(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
		push_bar(32'd10, 32'd5, 32'd7, 1'b1);
		push_bar(32'd12, 32'd6, 32'd9, 1'b0);
		set_period(9'd1);
		push_bar(32'd20, 32'd3, 32'd15, 1'b0);
		push_bar(32'd16, 32'd14, 32'd15, 1'b0);
		push_bar(32'hFFFF_FFFF, 32'h0, 32'd100, 1'b0);
		set_period(9'd0);
		push_bar(32'd50, 32'd40, 32'd45, 1'b1);
		push_bar(32'd60, 32'd30, 32'd35, 1'b0);
		push_bar(32'd38, 32'd33, 32'd36, 1'b0);
		set_period(9'd300);
		push_bar(32'd90, 32'd10, 32'd50, 1'b0);
		push_bar(32'd51, 32'd49, 32'd50, 1'b0);
		set_period(9'd5);
		push_bar(32'd1000, 32'd900, 32'd950, 1'b1);
		push_bar(32'd990, 32'd920, 32'd930, 1'b0);
		push_bar(32'd1100, 32'd800, 32'd1000, 1'b0);
		push_bar(32'd1005, 32'd995, 32'd1000, 1'b0);
		set_period(9'd2);
		push_bar(32'd1200, 32'd1000, 32'd1100, 1'b0);
		set_period(9'h1FF);
		push_bar(32'hFFFF_FFFF, 32'h0, 32'h0, 1'b0);
		push_bar(32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);

		while (bars_sent < BAR_TARGET) begin
			phase_no++;
			kind = (phase_no == 2) ? 0 : $urandom_range(0, 9);
			bar_count = $urandom_range(20, 80);
			case (kind)
				0: begin
					new_period = ($urandom_range(0, 2) == 0) ? 9'h1FF : 9'd256;
					bar_count = $urandom_range(260, 300);
				end
				1: new_period = 9'd0;
				2: new_period = 9'd1;
				3: new_period = 9'd2;
				4: new_period = PER_W'($urandom_range(1, 511));
				default: new_period = PER_W'($urandom_range(3, 30));
			endcase
			start_fresh = $urandom_range(0, 1);
			set_period(new_period);
			for (k = 0; k < bar_count; k++) begin
				next_bar = gen_bar();
				if (k == 0 && start_fresh)
					next_bar.rst = 1'b1;
				push_bar(next_bar.hi, next_bar.lo, next_bar.cl, next_bar.rst);
			end
		end

		wait_drained();
		repeat (100) @(posedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
`default_nettype wire
